FILE: src/partition_table_parser_core_macros.svh
// assertion macros shared by the partition table parser files
`ifndef PARTITION_TABLE_PARSER_CORE_MACROS_SVH
`define PARTITION_TABLE_PARSER_CORE_MACROS_SVH

// checked property, skipped while reset is asserted
`define PTP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked property, also checked during reset
`define PTP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/ptp_pkg.sv
// shared types and constants of the partition table parser
package ptp_pkg;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_DATA  = 2'd1;
	localparam logic [1:0] ACT_FAIL  = 2'd2;

	localparam logic [1:0] KIND_REQ    = 2'd0;
	localparam logic [1:0] KIND_RECORD = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;

	localparam logic [15:0] BOOT_SIG        = 16'hAA55;
	localparam logic [7:0]  PROTECTIVE_TYPE = 8'hEE;
	localparam logic [63:0] EFI_SIG         = 64'h5452415020494645;
	localparam logic [7:0]  GPT_TYPE        = 8'hFF;
	localparam int unsigned MBR_BASE        = 446;
	localparam int unsigned MBR_ENTRIES     = 4;
	localparam int unsigned ENTRY_MIN       = 48;
	localparam int unsigned ENTRY_MAX       = 512;
	localparam int unsigned NSLOTS          = 5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  port_out;
		logic [63:0] lba;
		logic [63:0] part_start;
		logic [63:0] part_len;
		logic [7:0]  part_type;
		logic        is_gpt;
		logic        outcome;
		logic [7:0]  found;
	} result_t;

	function automatic result_t mk_request(logic [4:0] p, logic [63:0] a);
		result_t r;
		r = '0;
		r.kind = KIND_REQ;
		r.port_out = p;
		r.lba = a;
		return r;
	endfunction

	function automatic result_t mk_finish(logic oc, logic [7:0] f);
		result_t r;
		r = '0;
		r.kind = KIND_FINISH;
		r.outcome = oc;
		r.found = f;
		return r;
	endfunction

	function automatic result_t mk_record(logic [63:0] s, logic [63:0] c, logic [7:0] t,
			logic g);
		result_t r;
		r = '0;
		r.kind = KIND_RECORD;
		r.part_start = s;
		r.part_len = c;
		r.part_type = t;
		r.is_gpt = g;
		return r;
	endfunction

endpackage

FILE: src/ptp_outbuf.sv
// result slots of one item, drained one result per cycle while out_ready is high, in slot order
`include "partition_table_parser_core_macros.svh"

module ptp_outbuf
	import ptp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic [NSLOTS-1:0]    load_vld,
	input  result_t              load_res [NSLOTS],
	output logic                 can_load,
	output logic                 out_valid,
	input  logic                 out_ready,
	output result_t              out_res,
	output logic                 out_last
);

	logic [NSLOTS-1:0] vld_q;
	result_t           res_q [NSLOTS];
	logic [NSLOTS-1:0] sel_oh;
	logic              take;

	// lowest pending slot goes out first
	always_comb begin
		sel_oh = '0;
		out_res = res_q[NSLOTS-1];
		for (int i = NSLOTS - 1; i >= 0; i--) begin
			if (vld_q[i]) begin
				sel_oh = '0;
				sel_oh[i] = 1'b1;
				out_res = res_q[i];
			end
		end
	end

	assign out_valid = |vld_q;
	assign out_last  = (vld_q & ~sel_oh) == '0;
	assign take      = out_valid && out_ready;
	assign can_load  = !out_valid || (out_last && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (load) begin
			vld_q <= load_vld;
		end else if (take) begin
			vld_q <= vld_q & ~sel_oh;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < NSLOTS; i++) res_q[i] <= load_res[i];
		end
	end

	`PTP_ASSERT(a_load_when_free, load |-> ($countones(vld_q) <= 1), "load over pending results")
	`PTP_ASSERT(a_load_shows, (load && (load_vld != '0)) |=> out_valid, "loaded results not shown")
	`PTP_ASSERT(a_drop_on_take, $fell(out_valid) |-> $past(out_ready), "result lost without take")

endmodule

FILE: src/partition_table_parser_core.sv
// partition table parser top level: byte stage, table decode and result slots
//
// channel  dir  tdata / tuser / tlast
// s_*      in   tdata {data_byte, port}, tuser action
// m_*      out  tdata {found, outcome, is_gpt, part_type, part_len, part_start,
//               lba, port_out}, tuser kind, tlast last
// cfg_*    in   max_partitions, written when cfg_we is high
//
// one byte enters per cycle while s_tready is high into an input register and is decoded there
// into up to five result slots; an item is accepted while results of the one before
// are still draining, as long as only the final one of them is left and m_tready is high
// an item with several results holds the input until only its final result is left
// (up to five results at the end of sector 0), and while m_tready is low with results pending
// reset clears the scan state, max_partitions returns to 16
`include "partition_table_parser_core_macros.svh"

module partition_table_parser_core
	import ptp_pkg::*;
#(
	parameter int unsigned SECTOR_BYTES = 512
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // port [4:0], data_byte [12:5]
	input  logic [1:0]   s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [215:0] m_tdata,   // port_out, lba, part_start, part_len, part_type,
	                                // is_gpt, outcome, found
	output logic [1:0]   m_tuser,   // kind
	output logic         m_tlast,
	input  logic         cfg_we,
	input  logic [7:0]   cfg_wdata
);

	localparam int unsigned POS_W = $clog2(SECTOR_BYTES);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(SECTOR_BYTES - 1);

	typedef enum logic [2:0] {PH_IDLE, PH_BOOT, PH_HEAD, PH_ENTRY} phase_t;

	// input stage
	logic       valid_s1;
	logic [1:0] action_s1;
	logic [4:0] port_s1;
	logic [7:0] byte_s1;

	// scan state
	phase_t           phase_q;
	logic [POS_W-1:0] pos_q;
	logic [4:0]       port_q;
	logic [7:0]       max_q;
	logic [7:0]       found_q;
	logic             sig_ok_q;
	logic [63:0]      table_lba_q;
	logic [31:0]      entry_total_q;
	logic [31:0]      entry_bytes_q;
	logic [31:0]      entry_index_q;
	logic [31:0]      sector_index_q;
	logic [9:0]       off_q;
	logic             guid_q;
	logic [63:0]      first_q;
	logic [63:0]      last_q;
	logic [7:0]       mbr_type_q  [MBR_ENTRIES];
	logic [31:0]      mbr_start_q [MBR_ENTRIES];
	logic [31:0]      mbr_cnt_q   [MBR_ENTRIES];
	logic [7:0]       sig_lo_q;
	logic [7:0]       sig_hi_q;

	logic              can_load, consume;
	logic [NSLOTS-1:0] slot_vld;
	result_t           slot_res [NSLOTS];
	result_t           out_res;

	logic             is_data, pos_end;
	logic [7:0]       sig_hi_now;
	logic [7:0]       mbr_found;
	logic             guid_n, entry_end, entry_rec, scan_done;
	logic [63:0]      first_n, last_n;
	logic [7:0]       found_entry;
	logic             head_bad;

	assign consume  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || can_load;
	assign is_data  = action_s1 == ACT_DATA;
	assign pos_end  = pos_q >= POS_LAST;
	assign sig_hi_now = (pos_q == POS_W'(511)) ? byte_s1 : sig_hi_q;

	// entry field accumulation including the byte at hand
	always_comb begin
		guid_n  = guid_q;
		first_n = first_q;
		last_n  = last_q;
		if (off_q < 10'd16) begin
			if (byte_s1 != 8'd0) guid_n = 1'b1;
		end else if (off_q >= 10'd32 && off_q < 10'd40) begin
			first_n = first_q | (64'(byte_s1) << {off_q[2:0], 3'b000});
		end else if (off_q >= 10'd40 && off_q < 10'd48) begin
			last_n = last_q | (64'(byte_s1) << {off_q[2:0], 3'b000});
		end
	end

	assign entry_end   = !((32'(off_q) + 32'd1) < entry_bytes_q);
	assign entry_rec   = entry_end && guid_n;
	assign found_entry = found_q + 8'(entry_rec);
	assign scan_done   = entry_end && (((entry_index_q + 32'd1) >= entry_total_q) ||
		(found_entry >= max_q));
	assign head_bad    = !sig_ok_q || (entry_bytes_q < 32'(ENTRY_MIN)) ||
		(entry_bytes_q > 32'(ENTRY_MAX)) || (entry_total_q == 32'd0) || (found_q >= max_q);

	// results of the item in the input stage
	always_comb begin
		logic [7:0] f;
		f = found_q;
		slot_vld = '0;
		for (int i = 0; i < NSLOTS; i++) slot_res[i] = '0;
		for (int i = 0; i < int'(MBR_ENTRIES); i++) begin
			slot_res[i] = mk_record(64'(mbr_start_q[i]), 64'(mbr_cnt_q[i]), mbr_type_q[i],
				1'b0);
		end
		priority if (action_s1 == ACT_START) begin
			slot_vld[NSLOTS-1] = 1'b1;
			slot_res[NSLOTS-1] = mk_request(port_s1, 64'd0);
		end else if (action_s1 == ACT_FAIL) begin
			if (phase_q == PH_BOOT || phase_q == PH_HEAD) begin
				slot_vld[NSLOTS-1] = 1'b1;
				slot_res[NSLOTS-1] = mk_finish(1'b1, found_q);
			end else if (phase_q == PH_ENTRY) begin
				slot_vld[NSLOTS-1] = 1'b1;
				slot_res[NSLOTS-1] = mk_finish(1'b0, found_q);
			end
		end else if (is_data && phase_q == PH_BOOT && pos_end) begin
			slot_vld[NSLOTS-1] = 1'b1;
			if ({sig_hi_now, sig_lo_q} != BOOT_SIG) begin
				slot_res[NSLOTS-1] = mk_finish(1'b0, found_q);
			end else if (mbr_type_q[0] == PROTECTIVE_TYPE) begin
				slot_res[NSLOTS-1] = mk_request(port_q, 64'd1);
			end else begin
				for (int i = 0; i < int'(MBR_ENTRIES); i++) begin
					if (f < max_q && mbr_type_q[i] != 8'd0) begin
						slot_vld[i] = 1'b1;
						f = f + 8'd1;
					end
				end
				slot_res[NSLOTS-1] = mk_finish(1'b0, f);
			end
		end else if (is_data && phase_q == PH_HEAD && pos_end) begin
			slot_vld[NSLOTS-1] = 1'b1;
			slot_res[NSLOTS-1] = head_bad ? mk_finish(1'b0, found_q) :
				mk_request(port_q, table_lba_q);
		end else if (is_data && phase_q == PH_ENTRY) begin
			slot_vld[0] = entry_rec;
			slot_res[0] = mk_record(first_n, last_n - first_n + 64'd1, GPT_TYPE, 1'b1);
			if (scan_done) begin
				slot_vld[NSLOTS-1] = 1'b1;
				slot_res[NSLOTS-1] = mk_finish(1'b0, found_entry);
			end else if (pos_end) begin
				slot_vld[NSLOTS-1] = 1'b1;
				slot_res[NSLOTS-1] = mk_request(port_q,
					table_lba_q + 64'(sector_index_q) + 64'd1);
			end
		end else begin
			slot_vld = '0;
		end
		mbr_found = f;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			max_q    <= 8'd16;
		end else begin
			if (s_tvalid && s_tready) valid_s1 <= 1'b1;
			else if (consume) valid_s1 <= 1'b0;
			if (cfg_we) max_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			action_s1 <= s_tuser;
			port_s1   <= s_tdata[4:0];
			byte_s1   <= s_tdata[12:5];
		end
	end

	// boot sector fields, captured as they pass
	always_ff @(posedge clk) begin
		if (consume && is_data && phase_q == PH_BOOT) begin
			for (int i = 0; i < int'(MBR_ENTRIES); i++) begin
				if (pos_q == POS_W'(MBR_BASE + 16 * i + 4)) mbr_type_q[i] <= byte_s1;
				for (int j = 0; j < 4; j++) begin
					if (pos_q == POS_W'(MBR_BASE + 16 * i + 8 + j))
						mbr_start_q[i][8*j +: 8] <= byte_s1;
					if (pos_q == POS_W'(MBR_BASE + 16 * i + 12 + j))
						mbr_cnt_q[i][8*j +: 8] <= byte_s1;
				end
			end
			if (pos_q == POS_W'(510)) sig_lo_q <= byte_s1;
			if (pos_q == POS_W'(511)) sig_hi_q <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			pos_q          <= '0;
			port_q         <= '0;
			found_q        <= '0;
			sig_ok_q       <= 1'b1;
			table_lba_q    <= '0;
			entry_total_q  <= '0;
			entry_bytes_q  <= '0;
			entry_index_q  <= '0;
			sector_index_q <= '0;
			off_q          <= '0;
			guid_q         <= 1'b0;
			first_q        <= '0;
			last_q         <= '0;
		end else if (consume) begin
			priority if (action_s1 == ACT_START) begin
				port_q   <= port_s1;
				phase_q  <= PH_BOOT;
				pos_q    <= '0;
				found_q  <= '0;
				sig_ok_q <= 1'b1;
			end else if (action_s1 == ACT_FAIL) begin
				phase_q <= PH_IDLE;
			end else if (is_data && phase_q == PH_BOOT) begin
				if (!pos_end) begin
					pos_q <= pos_q + POS_W'(1);
				end else if ({sig_hi_now, sig_lo_q} != BOOT_SIG) begin
					phase_q <= PH_IDLE;
				end else if (mbr_type_q[0] == PROTECTIVE_TYPE) begin
					phase_q       <= PH_HEAD;
					pos_q         <= '0;
					sig_ok_q      <= 1'b1;
					table_lba_q   <= '0;
					entry_total_q <= '0;
					entry_bytes_q <= '0;
				end else begin
					found_q <= mbr_found;
					phase_q <= PH_IDLE;
				end
			end else if (is_data && phase_q == PH_HEAD) begin
				if (pos_q < POS_W'(8)) begin
					if (byte_s1 != EFI_SIG[{pos_q[2:0], 3'b000} +: 8]) sig_ok_q <= 1'b0;
				end else if (pos_q >= POS_W'(72) && pos_q < POS_W'(80)) begin
					table_lba_q <= table_lba_q | (64'(byte_s1) << {pos_q[2:0], 3'b000});
				end else if (pos_q >= POS_W'(80) && pos_q < POS_W'(84)) begin
					entry_total_q <= entry_total_q | (32'(byte_s1) << {pos_q[1:0], 3'b000});
				end else if (pos_q >= POS_W'(84) && pos_q < POS_W'(88)) begin
					entry_bytes_q <= entry_bytes_q | (32'(byte_s1) << {pos_q[1:0], 3'b000});
				end
				if (!pos_end) begin
					pos_q <= pos_q + POS_W'(1);
				end else if (head_bad) begin
					phase_q <= PH_IDLE;
				end else begin
					phase_q        <= PH_ENTRY;
					pos_q          <= '0;
					entry_index_q  <= '0;
					sector_index_q <= '0;
					off_q          <= '0;
					guid_q         <= 1'b0;
					first_q        <= '0;
					last_q         <= '0;
				end
			end else if (is_data && phase_q == PH_ENTRY) begin
				found_q <= found_entry;
				if (entry_end) entry_index_q <= entry_index_q + 32'd1;
				// trailing bytes of a partial entry are dropped at the sector end
				if (entry_end || pos_end) begin
					off_q   <= '0;
					guid_q  <= 1'b0;
					first_q <= '0;
					last_q  <= '0;
				end else begin
					off_q   <= off_q + 10'd1;
					guid_q  <= guid_n;
					first_q <= first_n;
					last_q  <= last_n;
				end
				if (scan_done) begin
					phase_q <= PH_IDLE;
				end else if (pos_end) begin
					sector_index_q <= sector_index_q + 32'd1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end else begin
				phase_q <= phase_q;
			end
		end
	end

	ptp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume),
		.load_vld  (slot_vld),
		.load_res  (slot_res),
		.can_load  (can_load),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_res.kind;
	assign m_tdata = {1'b0, out_res.found, out_res.outcome, out_res.is_gpt, out_res.part_type,
		out_res.part_len, out_res.part_start, out_res.lba, out_res.port_out};

endmodule
